### src/sba_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and reset values for the slab buffer allocator.
// No dependencies; the RTL refers to it by scoped names, the testbench imports it.
package sba_pkg;

    localparam int NUM_TARGETS_DEF    = 4;
    localparam int NUM_SLAB_SIZES_DEF = 4;
    localparam int FREE_DEPTH_DEF     = 64;
    localparam int MAX_RESULTS_DEF    = 64;

    localparam int PLAN_DEPTH = 2;
    localparam int OUT_DEPTH  = 4;

    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int CFG_NUM_SLAB_REGS = 4;
    localparam int CFG_NUM_CAP_REGS  = 4;

    // slab index and slab count at their widest parameter range
    localparam int IDX_W = 3;
    localparam int CNT_W = 33;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLAB_BYTES_0      = 3'd0,
        CFG_SLAB_BYTES_1      = 3'd1,
        CFG_SLAB_BYTES_2      = 3'd2,
        CFG_SLAB_BYTES_3      = 3'd3,
        CFG_CAPACITY_TARGET_0 = 3'd4,
        CFG_CAPACITY_TARGET_1 = 3'd5,
        CFG_CAPACITY_TARGET_2 = 3'd6,
        CFG_CAPACITY_TARGET_3 = 3'd7
    } t_cfg_reg;

    typedef enum logic [0:0] {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_SPACE    = 2'd1,
        ST_LIMIT       = 2'd2,
        ST_STACK_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PK_RELEASE = 2'd0,
        PK_ALLOC   = 2'd1,
        PK_BAD     = 2'd2
    } t_plan_kind;

    typedef enum logic [1:0] {
        F_IDLE  = 2'd0,
        F_CLASS = 2'd1,
        F_DIV   = 2'd2,
        F_EMIT  = 2'd3
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE = 3'd0,
        B_SLAB = 3'd1,
        B_READ = 3'd2,
        B_REL  = 3'd3,
        B_BAD  = 3'd4
    } t_back_state;

    typedef struct packed {
        t_op         operation;
        logic [1:0]  target;
        logic [31:0] request_bytes;
        logic [1:0]  release_slab;
        logic [31:0] release_offset;
    } t_req;

    typedef struct packed {
        logic [1:0]  out_target;
        logic [31:0] out_offset;
        logic [1:0]  out_slab;
        logic [31:0] slab_length;
        logic [31:0] blob_offset;
        logic [31:0] blob_length;
        t_status     status;
        logic        last;
    } t_result;

    // Work for the back end: an allocation is at most one slab of first_slab
    // followed by main_cnt slabs of main_slab.
    typedef struct packed {
        t_plan_kind       kind;
        logic [1:0]       target;
        logic [31:0]      request_bytes;
        logic [1:0]       release_slab;
        logic [31:0]      release_offset;
        logic             first_vld;
        logic [IDX_W-1:0] first_slab;
        logic [IDX_W-1:0] main_slab;
        logic [CNT_W-1:0] main_cnt;
    } t_plan;

    function automatic logic [31:0] slab_reset(input int idx);
        case (idx)
            0:       slab_reset = 32'd4096;
            1:       slab_reset = 32'd16384;
            2:       slab_reset = 32'd65536;
            default: slab_reset = 32'd1048576;
        endcase
    endfunction

    function automatic logic [31:0] cap_reset(input int idx);
        case (idx)
            0:       cap_reset = 32'd16777216;
            1:       cap_reset = 32'd67108864;
            2:       cap_reset = 32'd268435456;
            3:       cap_reset = 32'hFFFF_FFFF;
            default: cap_reset = 32'd0;
        endcase
    endfunction

endpackage

### src/sba_fifo.sv
`timescale 1ns / 1ps
// Small show-ahead register queue used as the plan queue and the result queue.
// Depends on nothing but its parameters.
module sba_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### src/sba_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, splits an allocation into slab counts with a
// bit-serial divider and hands a plan to the back end. Uses sba_pkg.
module sba_front #(
    parameter int NUM_TARGETS    = sba_pkg::NUM_TARGETS_DEF,
    parameter int NUM_SLAB_SIZES = sba_pkg::NUM_SLAB_SIZES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sba_pkg::t_req      i_req,
    output logic               o_full,
    input  logic [31:0]        i_slab_sz [NUM_SLAB_SIZES],
    output logic               o_plan_push,
    output sba_pkg::t_plan     o_plan,
    input  logic               i_plan_full
);
    localparam int IW = sba_pkg::IDX_W;
    localparam int NW = sba_pkg::CNT_W;

    sba_pkg::t_front_state r_state, n_state;
    sba_pkg::t_req         r_req, n_req;
    sba_pkg::t_plan        r_plan, n_plan;
    logic [31:0]           r_quo, n_quo;
    logic [31:0]           r_rem, n_rem;
    logic [5:0]            r_bit, n_bit;

    logic [31:0] sz_last;
    logic [31:0] fit_val;
    logic        fit_vld;
    logic [IW-1:0] fit_idx;
    logic [32:0] shl;
    logic        ge;

    assign sz_last     = i_slab_sz[NUM_SLAB_SIZES-1];
    assign o_full      = (r_state != sba_pkg::F_IDLE);
    assign o_plan      = r_plan;
    assign o_plan_push = (r_state == sba_pkg::F_EMIT);

    // first slab size that holds the value
    always_comb begin
        fit_val = (r_state == sba_pkg::F_CLASS) ? r_req.request_bytes : r_rem;
        fit_vld = 1'b0;
        fit_idx = '0;
        for (int k = NUM_SLAB_SIZES - 1; k >= 0; k--) begin
            if (i_slab_sz[k] >= fit_val) begin
                fit_vld = 1'b1;
                fit_idx = IW'(k);
            end
        end
    end

    assign shl = {r_rem, r_quo[31]};
    assign ge  = (shl >= {1'b0, sz_last});

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_plan  = r_plan;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_bit   = r_bit;
        case (r_state)
            sba_pkg::F_IDLE: begin
                if (i_push) begin
                    n_req   = i_req;
                    n_state = sba_pkg::F_CLASS;
                end
            end
            sba_pkg::F_CLASS: begin
                n_plan                = '0;
                n_plan.target         = r_req.target;
                n_plan.request_bytes  = r_req.request_bytes;
                n_plan.release_slab   = r_req.release_slab;
                n_plan.release_offset = r_req.release_offset;
                n_plan.main_cnt       = NW'(1);
                n_plan.main_slab      = fit_idx;
                if (r_req.operation == sba_pkg::OP_RELEASE) begin
                    n_plan.kind = sba_pkg::PK_RELEASE;
                    n_state     = sba_pkg::F_EMIT;
                end else if (r_req.request_bytes == '0) begin
                    // zero bytes: drop the transaction
                    n_state = sba_pkg::F_IDLE;
                end else if (int'(r_req.target) >= NUM_TARGETS) begin
                    n_plan.kind = sba_pkg::PK_BAD;
                    n_state     = sba_pkg::F_EMIT;
                end else if (fit_vld) begin
                    n_plan.kind = sba_pkg::PK_ALLOC;
                    n_state     = sba_pkg::F_EMIT;
                end else begin
                    n_plan.kind = sba_pkg::PK_ALLOC;
                    n_quo       = r_req.request_bytes;
                    n_rem       = '0;
                    n_bit       = '0;
                    n_state     = sba_pkg::F_DIV;
                end
            end
            sba_pkg::F_DIV: begin
                if (r_bit == 6'd32) begin
                    // quotient of the largest size, remainder takes one more slab
                    n_plan.main_slab = IW'(NUM_SLAB_SIZES - 1);
                    n_plan.main_cnt  = {1'b0, r_quo};
                    if (r_rem != '0) begin
                        if (fit_idx == IW'(NUM_SLAB_SIZES - 1)) begin
                            n_plan.main_cnt = {1'b0, r_quo} + NW'(1);
                        end else begin
                            n_plan.first_vld  = 1'b1;
                            n_plan.first_slab = fit_idx;
                        end
                    end
                    n_state = sba_pkg::F_EMIT;
                end else begin
                    n_rem = ge ? 32'(shl - {1'b0, sz_last}) : shl[31:0];
                    n_quo = {r_quo[30:0], ge};
                    n_bit = r_bit + 6'd1;
                end
            end
            sba_pkg::F_EMIT: begin
                if (!i_plan_full) begin
                    n_state = sba_pkg::F_IDLE;
                end
            end
            default: n_state = sba_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sba_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_plan <= n_plan;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_bit  <= n_bit;
    end

endmodule

### src/sba_back.sv
`timescale 1ns / 1ps
// Back end: carries out plans slab by slab from the free stacks and bump
// regions and writes result transactions. Uses sba_pkg.
module sba_back #(
    parameter int NUM_TARGETS    = sba_pkg::NUM_TARGETS_DEF,
    parameter int NUM_SLAB_SIZES = sba_pkg::NUM_SLAB_SIZES_DEF,
    parameter int FREE_DEPTH     = sba_pkg::FREE_DEPTH_DEF,
    parameter int MAX_RESULTS    = sba_pkg::MAX_RESULTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [31:0]        i_slab_sz [NUM_SLAB_SIZES],
    input  logic [31:0]        i_cap [NUM_TARGETS],
    input  logic               i_plan_empty,
    input  sba_pkg::t_plan     i_plan,
    output logic               o_plan_pop,
    output logic               o_out_push,
    output sba_pkg::t_result   o_out,
    input  logic               i_out_full
);
    localparam int TW   = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
    localparam int SW   = (NUM_SLAB_SIZES > 1) ? $clog2(NUM_SLAB_SIZES) : 1;
    localparam int NS   = NUM_TARGETS * NUM_SLAB_SIZES;
    localparam int SIDW = (NS > 1) ? $clog2(NS) : 1;
    localparam int AW   = (NS * FREE_DEPTH > 1) ? $clog2(NS * FREE_DEPTH) : 1;
    localparam int CW   = $clog2(FREE_DEPTH + 1);
    localparam int RW   = $clog2(MAX_RESULTS + 1);
    localparam int NW   = sba_pkg::CNT_W;

    sba_pkg::t_back_state r_state, n_state;
    sba_pkg::t_plan       r_plan, n_plan;
    logic [TW-1:0]  r_t, n_t;
    logic [SW-1:0]  r_s, n_s;
    logic [NW-1:0]  r_left, n_left;
    logic [NW-1:0]  r_total, n_total;
    logic [RW-1:0]  r_n, n_n;
    logic [31:0]    r_boff, n_boff;
    logic [31:0]    r_remb, n_remb;

    logic [CW-1:0]  r_cnt [NS];
    logic [31:0]    r_bump [NUM_TARGETS];
    logic [31:0]    r_mem [NS * FREE_DEPTH];
    logic [31:0]    r_rd_data;

    logic [TW-1:0]  cur_t;
    logic [SW-1:0]  cur_s;
    logic [SIDW-1:0] sid;
    logic [CW-1:0]  cnt_cur;
    logic [31:0]    sz, cap, bump, blen, take_off;
    logic           rel_ok, bump_fits, take;
    logic           cnt_inc, cnt_dec, bump_we, mem_we, mem_re;
    logic [AW-1:0]  wr_addr, rd_addr;

    always_comb begin
        if (r_state == sba_pkg::B_REL) begin
            cur_t = TW'(r_plan.target);
            cur_s = SW'(r_plan.release_slab);
        end else begin
            cur_t = r_t;
            cur_s = r_s;
        end
    end

    assign sid     = SIDW'(int'(cur_t) * NUM_SLAB_SIZES + int'(cur_s));
    assign cnt_cur = r_cnt[sid];
    assign sz      = i_slab_sz[cur_s];
    assign cap     = i_cap[r_t];
    assign bump    = r_bump[r_t];
    assign rel_ok  = (int'(r_plan.target) < NUM_TARGETS)
                  && (int'(r_plan.release_slab) < NUM_SLAB_SIZES)
                  && (int'(cnt_cur) < FREE_DEPTH);
    assign bump_fits = (bump <= cap) && ((cap - bump) >= sz);
    assign blen      = (r_remb < sz) ? r_remb : sz;
    assign wr_addr   = AW'(int'(sid) * FREE_DEPTH + int'(cnt_cur));
    assign rd_addr   = AW'(int'(sid) * FREE_DEPTH + int'(cnt_cur) - 1);

    always_comb begin
        n_state    = r_state;
        n_plan     = r_plan;
        n_t        = r_t;
        n_s        = r_s;
        n_left     = r_left;
        n_total    = r_total;
        n_n        = r_n;
        n_boff     = r_boff;
        n_remb     = r_remb;
        o_plan_pop = 1'b0;
        o_out_push = 1'b0;
        o_out      = '0;
        cnt_inc    = 1'b0;
        cnt_dec    = 1'b0;
        bump_we    = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        take       = 1'b0;
        take_off   = bump;
        case (r_state)
            sba_pkg::B_IDLE: begin
                if (!i_plan_empty) begin
                    o_plan_pop = 1'b1;
                    n_plan     = i_plan;
                    n_t        = TW'(i_plan.target);
                    n_boff     = '0;
                    n_remb     = i_plan.request_bytes;
                    n_n        = '0;
                    n_total    = i_plan.main_cnt + NW'(i_plan.first_vld);
                    if (i_plan.first_vld) begin
                        n_s    = SW'(i_plan.first_slab);
                        n_left = NW'(1);
                    end else begin
                        n_s    = SW'(i_plan.main_slab);
                        n_left = i_plan.main_cnt;
                    end
                    case (i_plan.kind)
                        sba_pkg::PK_RELEASE: n_state = sba_pkg::B_REL;
                        sba_pkg::PK_ALLOC:   n_state = sba_pkg::B_SLAB;
                        default:             n_state = sba_pkg::B_BAD;
                    endcase
                end
            end
            sba_pkg::B_REL: begin
                if (!i_out_full) begin
                    o_out_push         = 1'b1;
                    o_out.out_target   = r_plan.target;
                    o_out.out_offset   = r_plan.release_offset;
                    o_out.out_slab     = r_plan.release_slab;
                    o_out.slab_length  = (int'(r_plan.release_slab) < NUM_SLAB_SIZES) ? sz : '0;
                    o_out.status       = rel_ok ? sba_pkg::ST_OK : sba_pkg::ST_STACK_FULL;
                    o_out.last         = 1'b1;
                    cnt_inc            = rel_ok;
                    mem_we             = rel_ok;
                    n_state            = sba_pkg::B_IDLE;
                end
            end
            sba_pkg::B_BAD: begin
                if (!i_out_full) begin
                    o_out_push        = 1'b1;
                    o_out.out_target  = r_plan.target;
                    o_out.blob_length = r_plan.request_bytes;
                    o_out.status      = sba_pkg::ST_NO_SPACE;
                    o_out.last        = 1'b1;
                    n_state           = sba_pkg::B_IDLE;
                end
            end
            sba_pkg::B_SLAB: begin
                if (!i_out_full) begin
                    o_out.out_slab    = 2'(r_s);
                    o_out.slab_length = sz;
                    o_out.blob_offset = r_boff;
                    o_out.blob_length = r_remb;
                    o_out.last        = 1'b1;
                    if (int'(r_n) == MAX_RESULTS - 1 && r_total > NW'(1)) begin
                        o_out_push       = 1'b1;
                        o_out.out_target = 2'(r_t);
                        o_out.status     = sba_pkg::ST_LIMIT;
                        n_state          = sba_pkg::B_IDLE;
                    end else if (cnt_cur != '0) begin
                        // pop: stack data arrives next cycle
                        cnt_dec = 1'b1;
                        mem_re  = 1'b1;
                        n_state = sba_pkg::B_READ;
                    end else if (bump_fits) begin
                        bump_we = 1'b1;
                        take    = 1'b1;
                    end else if (r_t == TW'(NUM_TARGETS - 1)) begin
                        o_out_push       = 1'b1;
                        o_out.out_target = 2'(NUM_TARGETS - 1);
                        o_out.status     = sba_pkg::ST_NO_SPACE;
                        n_state          = sba_pkg::B_IDLE;
                    end else begin
                        n_t = r_t + 1'b1;
                    end
                end
            end
            sba_pkg::B_READ: begin
                take     = 1'b1;
                take_off = r_rd_data;
                n_state  = sba_pkg::B_SLAB;
            end
            default: n_state = sba_pkg::B_IDLE;
        endcase

        if (take) begin
            o_out_push        = 1'b1;
            o_out.out_target  = 2'(r_t);
            o_out.out_offset  = take_off;
            o_out.out_slab    = 2'(r_s);
            o_out.slab_length = sz;
            o_out.blob_offset = r_boff;
            o_out.blob_length = blen;
            o_out.status      = sba_pkg::ST_OK;
            o_out.last        = (r_total == NW'(1));
            n_boff            = r_boff + blen;
            n_remb            = r_remb - blen;
            n_n               = r_n + 1'b1;
            n_total           = r_total - NW'(1);
            n_left            = r_left - NW'(1);
            if (r_total == NW'(1)) begin
                n_state = sba_pkg::B_IDLE;
            end else begin
                n_state = sba_pkg::B_SLAB;
                if (r_left == NW'(1)) begin
                    n_s    = SW'(r_plan.main_slab);
                    n_left = r_plan.main_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sba_pkg::B_IDLE;
            for (int k = 0; k < NS; k++) begin
                r_cnt[k] <= '0;
            end
            for (int k = 0; k < NUM_TARGETS; k++) begin
                r_bump[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (cnt_inc) begin
                r_cnt[sid] <= cnt_cur + 1'b1;
            end else if (cnt_dec) begin
                r_cnt[sid] <= cnt_cur - 1'b1;
            end
            if (bump_we) begin
                r_bump[r_t] <= bump + sz;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_plan  <= n_plan;
        r_t     <= n_t;
        r_s     <= n_s;
        r_left  <= n_left;
        r_total <= n_total;
        r_n     <= n_n;
        r_boff  <= n_boff;
        r_remb  <= n_remb;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= r_plan.release_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> !i_out_full)
        else $error("result written into a full queue");

    a_read_follows_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sba_pkg::B_READ) |-> $past(r_state) == sba_pkg::B_SLAB)
        else $error("stack read without a pop");

    a_result_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sba_pkg::B_SLAB) |-> int'(r_n) <= MAX_RESULTS - 1)
        else $error("result count passed the limit");

    a_one_result_per_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sba_pkg::B_REL && o_out_push) |=> r_state == sba_pkg::B_IDLE)
        else $error("release gave more than one result");
`endif

endmodule

### src/slab_buffer_allocator.sv
`timescale 1ns / 1ps
// Top level of the slab buffer allocator: configuration registers, the plan
// queue, the result queue and both ends. Uses sba_pkg, sba_fifo, sba_front, sba_back.
//
// Usage:
//   Input queue: drive i_req and raise push while full is low; each such edge
//   takes one transaction (allocate or release).
//   Result queue: while empty is low, o_rsp holds the oldest result; pop takes
//   it. The final result of a transaction carries last.
//   Configuration: i_cfg_we with i_cfg_idx/i_cfg_wdata writes one register;
//   write only while the block is idle.
// Timing:
//   The front end goes idle, class, emit for a release or one-slab request and
//   adds a one-bit-per-cycle divider when the largest size splits a request.
//   The back end gives one slab per cycle from a bump region while the result
//   queue has room, a free-stack slab via a pop and a read state (registered
//   stack RAM read); skipping a target takes a slab-state pass. The two-entry
//   plan queue lets the front end split the next request while the back end runs.
// Reset clears the stack counts and bump offsets and loads the default sizes;
// stack RAM contents are not cleared. When the receiver stalls the result
// queue fills, the back end holds, then the plan queue and finally full rises.
module slab_buffer_allocator #(
    parameter int NUM_TARGETS    = sba_pkg::NUM_TARGETS_DEF,
    parameter int NUM_SLAB_SIZES = sba_pkg::NUM_SLAB_SIZES_DEF,
    parameter int FREE_DEPTH     = sba_pkg::FREE_DEPTH_DEF,
    parameter int MAX_RESULTS    = sba_pkg::MAX_RESULTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    input  sba_pkg::t_req                     i_req,
    output logic                              full,
    output logic                              empty,
    input  logic                              pop,
    output sba_pkg::t_result                  o_rsp,
    input  logic                              i_cfg_we,
    input  logic [sba_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sba_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    localparam int PLAN_W = $bits(sba_pkg::t_plan);
    localparam int RSP_W  = $bits(sba_pkg::t_result);

    logic [31:0] r_slab [NUM_SLAB_SIZES];
    logic [31:0] r_cap  [NUM_TARGETS];

    logic             plan_push, plan_full, plan_pop, plan_empty;
    sba_pkg::t_plan   plan_in, plan_out;
    logic [PLAN_W-1:0] plan_q;
    logic             out_push, out_full;
    sba_pkg::t_result out_in;
    logic [RSP_W-1:0] rsp_q;

    for (genvar g = 0; g < NUM_SLAB_SIZES; g++) begin : g_slab
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_slab[g] <= sba_pkg::slab_reset(g);
            end else if (i_cfg_we && g < sba_pkg::CFG_NUM_SLAB_REGS
                         && int'(i_cfg_idx) == int'(sba_pkg::CFG_SLAB_BYTES_0) + g) begin
                // a zero size is stored as one byte
                r_slab[g] <= (i_cfg_wdata == '0) ? 32'd1 : i_cfg_wdata;
            end
        end
    end

    for (genvar g = 0; g < NUM_TARGETS; g++) begin : g_cap
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cap[g] <= sba_pkg::cap_reset(g);
            end else if (i_cfg_we && g < sba_pkg::CFG_NUM_CAP_REGS
                         && int'(i_cfg_idx) == int'(sba_pkg::CFG_CAPACITY_TARGET_0) + g) begin
                r_cap[g] <= i_cfg_wdata;
            end
        end
    end

    sba_front #(
        .NUM_TARGETS    (NUM_TARGETS),
        .NUM_SLAB_SIZES (NUM_SLAB_SIZES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_req       (i_req),
        .o_full      (full),
        .i_slab_sz   (r_slab),
        .o_plan_push (plan_push),
        .o_plan      (plan_in),
        .i_plan_full (plan_full)
    );

    sba_fifo #(
        .WIDTH (PLAN_W),
        .DEPTH (sba_pkg::PLAN_DEPTH)
    ) u_plan_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (plan_push),
        .i_data  (plan_in),
        .o_full  (plan_full),
        .i_pop   (plan_pop),
        .o_data  (plan_q),
        .o_empty (plan_empty)
    );

    assign plan_out = sba_pkg::t_plan'(plan_q);

    sba_back #(
        .NUM_TARGETS    (NUM_TARGETS),
        .NUM_SLAB_SIZES (NUM_SLAB_SIZES),
        .FREE_DEPTH     (FREE_DEPTH),
        .MAX_RESULTS    (MAX_RESULTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_slab_sz    (r_slab),
        .i_cap        (r_cap),
        .i_plan_empty (plan_empty),
        .i_plan       (plan_out),
        .o_plan_pop   (plan_pop),
        .o_out_push   (out_push),
        .o_out        (out_in),
        .i_out_full   (out_full)
    );

    sba_fifo #(
        .WIDTH (RSP_W),
        .DEPTH (sba_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (rsp_q),
        .o_empty (empty)
    );

    assign o_rsp = sba_pkg::t_result'(rsp_q);

endmodule

### tb/slab_buffer_allocator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for slab_buffer_allocator: directed and random
// allocate/release transactions checked against a behavioral predictor.
// Depends on sba_pkg and the slab_buffer_allocator RTL.
module slab_buffer_allocator_test;
    import sba_pkg::*;

    localparam int NTGT   = 4;
    localparam int NSIZE  = 4;
    localparam int DEPTH  = 64;
    localparam int MAXRES = 64;
    localparam longint CYCLE_LIMIT = 3000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    t_req        i_req;
    logic        full;
    logic        empty;
    logic        pop;
    t_result     o_rsp;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    slab_buffer_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .i_req(i_req), .full(full),
        .empty(empty), .pop(pop), .o_rsp(o_rsp), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    // predictor state
    logic [31:0] slab_len  [NSIZE];
    logic [31:0] cap       [NTGT];
    logic [31:0] stack_mem [NTGT*NSIZE][DEPTH];
    int          stack_cnt [NTGT*NSIZE];
    logic [31:0] bump      [NTGT];
    // offsets handed out and not yet released, for well-formed releases
    logic [35:0] held_slabs [$];

    t_result expected_rsp [$];
    int      err_cnt;
    longint  cycle_cnt;
    int      stall_mode;
    int      gap_max;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic add_rsp(input t_result r);
        expected_rsp.push_back(r);
    endtask

    function automatic t_result mk_rsp(input logic [1:0] tg, input logic [31:0] off,
                                       input logic [1:0] sl, input logic [31:0] len,
                                       input logic [31:0] boff, input logic [31:0] blen,
                                       input t_status st, input logic lst);
        t_result r;
        r.out_target  = tg;
        r.out_offset  = off;
        r.out_slab    = sl;
        r.slab_length = len;
        r.blob_offset = boff;
        r.blob_length = blen;
        r.status      = st;
        r.last        = lst;
        return r;
    endfunction

    task automatic reset_predictor();
        for (int i = 0; i < NSIZE; i++) slab_len[i] = slab_reset(i);
        for (int i = 0; i < NTGT; i++) begin
            cap[i]  = cap_reset(i);
            bump[i] = '0;
        end
        for (int i = 0; i < NTGT*NSIZE; i++) stack_cnt[i] = 0;
    endtask

    // compute expected results of one transaction and update state
    task automatic predict_alloc(input t_req q);
        longint unsigned cnt [NSIZE];
        longint unsigned total;
        logic [31:0] rem, boff, remb, sz, off, blen;
        int i, s, n, tg, sid;
        t_result r;
        if (q.operation == OP_RELEASE) begin
            sid = q.target * NSIZE + q.release_slab;
            r = mk_rsp(q.target, q.release_offset, q.release_slab,
                       slab_len[q.release_slab], '0, '0, ST_STACK_FULL, 1'b1);
            if (stack_cnt[sid] < DEPTH) begin
                stack_mem[sid][stack_cnt[sid]] = q.release_offset;
                stack_cnt[sid]++;
                r.status = ST_OK;
            end
            add_rsp(r);
            return;
        end
        if (q.request_bytes == 0) return;
        for (i = 0; i < NSIZE; i++) cnt[i] = 0;
        rem = q.request_bytes;
        while (rem != 0) begin
            i = 0;
            while (i < NSIZE && slab_len[i] < rem) i++;
            if (i == NSIZE) i--;
            sz = slab_len[i];
            if (rem > sz) begin
                cnt[i] += rem / sz;
                rem = rem % sz;
            end else begin
                cnt[i] += 1;
                rem = 0;
            end
        end
        total = 0;
        for (i = 0; i < NSIZE; i++) total += cnt[i];
        n = 0;
        boff = 0;
        remb = q.request_bytes;
        tg = q.target;
        for (s = 0; s < NSIZE; s++) begin
            sz = slab_len[s];
            while (cnt[s] != 0) begin
                if (n == MAXRES - 1 && total > 1) begin
                    add_rsp(mk_rsp(2'(tg), '0, 2'(s), sz, boff, remb, ST_LIMIT, 1'b1));
                    return;
                end
                sid = tg * NSIZE + s;
                if (stack_cnt[sid] != 0) begin
                    stack_cnt[sid]--;
                    off = stack_mem[sid][stack_cnt[sid]];
                end else if (bump[tg] <= cap[tg] && cap[tg] - bump[tg] >= sz) begin
                    off = bump[tg];
                    bump[tg] += sz;
                end else begin
                    tg++;
                    if (tg >= NTGT) begin
                        add_rsp(mk_rsp(2'(NTGT-1), '0, 2'(s), sz, boff, remb,
                                       ST_NO_SPACE, 1'b1));
                        return;
                    end
                    continue;
                end
                blen = remb < sz ? remb : sz;
                add_rsp(mk_rsp(2'(tg), off, 2'(s), sz, boff, blen, ST_OK, 1'b0));
                held_slabs.push_back({tg[1:0], s[1:0], off});
                boff += blen;
                remb -= blen;
                n++;
                cnt[s]--;
                total--;
            end
        end
        if (n > 0) expected_rsp[$].last = 1'b1;
    endtask

    // hold push high after a transaction so bursts run back to back
    task automatic send_item(input t_req q);
        if ($urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(negedge i_clk);
        end
        push  <= 1'b1;
        i_req <= q;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_alloc(q);
        @(negedge i_clk);
    endtask

    function automatic t_req alloc_req(input logic [1:0] tg, input logic [31:0] bytes);
        t_req q;
        q.operation      = OP_ALLOC;
        q.target         = tg;
        q.request_bytes  = bytes;
        q.release_slab   = 2'($urandom);
        q.release_offset = $urandom;
        return q;
    endfunction

    function automatic t_req release_req(input logic [1:0] tg, input logic [1:0] sl,
                                         input logic [31:0] off);
        t_req q;
        q.operation      = OP_RELEASE;
        q.target         = tg;
        q.request_bytes  = $urandom;
        q.release_slab   = sl;
        q.release_offset = off;
        return q;
    endfunction

    task automatic drain();
        push <= 1'b0;
        while (expected_rsp.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [31:0] val);
        push        <= 1'b0;
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        if (idx <= CFG_SLAB_BYTES_3) slab_len[idx] = (val == 0) ? 32'd1 : val;
        else cap[idx - CFG_CAPACITY_TARGET_0] = val;
    endtask

    // check every popped result against the oldest expectation
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && pop && !empty) begin
            if (expected_rsp.size() == 0) begin
                $error("unexpected result %p", o_rsp);
                err_cnt++;
            end else begin
                e = expected_rsp.pop_front();
                if (o_rsp.out_target !== e.out_target) begin
                    $error("out_target exp %0d got %0d", e.out_target, o_rsp.out_target);
                    err_cnt++;
                end
                if (o_rsp.out_offset !== e.out_offset) begin
                    $error("out_offset exp %0h got %0h", e.out_offset, o_rsp.out_offset);
                    err_cnt++;
                end
                if (o_rsp.out_slab !== e.out_slab) begin
                    $error("out_slab exp %0d got %0d", e.out_slab, o_rsp.out_slab);
                    err_cnt++;
                end
                if (o_rsp.slab_length !== e.slab_length) begin
                    $error("slab_length exp %0h got %0h", e.slab_length, o_rsp.slab_length);
                    err_cnt++;
                end
                if (o_rsp.blob_offset !== e.blob_offset) begin
                    $error("blob_offset exp %0h got %0h", e.blob_offset, o_rsp.blob_offset);
                    err_cnt++;
                end
                if (o_rsp.blob_length !== e.blob_length) begin
                    $error("blob_length exp %0h got %0h", e.blob_length, o_rsp.blob_length);
                    err_cnt++;
                end
                if (o_rsp.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_rsp.status);
                    err_cnt++;
                end
                if (o_rsp.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_rsp.last);
                    err_cnt++;
                end
            end
        end
    end

    // receiver stall pattern: mode 0 never stalls, 1 random, 2 long periodic stalls
    always @(negedge i_clk) begin
        case (stall_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 2) != 0);
            default: pop <= ((cycle_cnt % 40) < 25);
        endcase
    end

    task automatic test_directed_alloc();
        send_item(alloc_req(2'd0, 32'd0));            // no results
        send_item(alloc_req(2'd0, 32'd1));
        send_item(alloc_req(2'd1, 32'd4096));
        send_item(alloc_req(2'd2, 32'd4097));
        send_item(alloc_req(2'd3, 32'd70000));
        send_item(alloc_req(2'd0, 32'd3145728 + 32'd5000));
        send_item(alloc_req(2'd0, 32'hFFFF_FFFF));   // result limit
        drain();
    endtask

    task automatic test_directed_release();
        send_item(release_req(2'd0, 2'd0, 32'd0));
        send_item(release_req(2'd3, 2'd3, 32'hFFFF_FFFF));
        send_item(alloc_req(2'd0, 32'd100));         // pops the stacked offset
        // fill one stack to overflow
        for (int i = 0; i < DEPTH + 2; i++)
            send_item(release_req(2'd1, 2'd2, $urandom));
        drain();
    endtask

    task automatic test_exhaustion();
        write_reg(CFG_SLAB_BYTES_0, 32'd0);
        write_reg(CFG_SLAB_BYTES_1, 32'd8);
        write_reg(CFG_SLAB_BYTES_2, 32'd64);
        write_reg(CFG_SLAB_BYTES_3, 32'd256);
        write_reg(CFG_CAPACITY_TARGET_0, 32'd0);
        write_reg(CFG_CAPACITY_TARGET_1, 32'd300);
        write_reg(CFG_CAPACITY_TARGET_2, 32'd100);   // shrunk below bump offset
        write_reg(CFG_CAPACITY_TARGET_3, 32'd1000);
        send_item(alloc_req(2'd0, 32'd700));
        send_item(alloc_req(2'd2, 32'd5000));        // out of space
        drain();
    endtask

    task automatic random_phase(input int items);
        t_req q;
        logic [35:0] h;
        int k;
        int j;
        for (int i = 0; i < items; i++) begin
            k = $urandom_range(0, 9);
            if (k < 5) begin
                case ($urandom_range(0, 3))
                    0: q = alloc_req(2'($urandom), $urandom_range(1, slab_len[0]));
                    1: q = alloc_req(2'($urandom), $urandom_range(1, slab_len[2]));
                    2: q = alloc_req(2'($urandom),
                                     $urandom_range(1, slab_len[3] * 6 + 1));
                    default: q = alloc_req(2'($urandom), $urandom);
                endcase
            end else if (k < 9 && held_slabs.size() != 0) begin
                j = $urandom_range(0, held_slabs.size() - 1);
                h = held_slabs[j];
                held_slabs.delete(j);
                q = release_req(h[35:34], h[33:32], h[31:0]);
            end else begin
                q = release_req(2'($urandom), 2'($urandom), $urandom);
            end
            if ($urandom_range(0, 20) == 0) gap_max = $urandom_range(1, 12);
            send_item(q);
        end
        drain();
    endtask

    task automatic test_random();
        gap_max = 1;
        stall_mode = 0;
        random_phase(40);
        stall_mode = 1;
        gap_max = 6;
        write_reg(CFG_SLAB_BYTES_0, 32'd1);
        write_reg(CFG_SLAB_BYTES_1, 32'd100);
        write_reg(CFG_SLAB_BYTES_2, 32'd1000);
        write_reg(CFG_SLAB_BYTES_3, 32'd5000);
        write_reg(CFG_CAPACITY_TARGET_0, 32'd50000);
        write_reg(CFG_CAPACITY_TARGET_1, 32'd80000);
        write_reg(CFG_CAPACITY_TARGET_2, 32'd200000);
        write_reg(CFG_CAPACITY_TARGET_3, 32'hFFFF_FFFF);
        random_phase(80);
        stall_mode = 2;
        write_reg(CFG_SLAB_BYTES_0, 32'hFFFF_FFFF);
        write_reg(CFG_SLAB_BYTES_1, 32'hFFFF_FFFF);
        write_reg(CFG_SLAB_BYTES_2, 32'hFFFF_FFFF);
        write_reg(CFG_SLAB_BYTES_3, 32'hFFFF_FFFF);
        write_reg(CFG_CAPACITY_TARGET_3, 32'hFFFF_FFFF);
        random_phase(20);
        stall_mode = 1;
        write_reg(CFG_SLAB_BYTES_0, 32'd4096);
        write_reg(CFG_SLAB_BYTES_1, 32'd16384);
        write_reg(CFG_SLAB_BYTES_2, 32'd65536);
        write_reg(CFG_SLAB_BYTES_3, 32'd1048576);
        random_phase(60);
    endtask

    initial begin
        err_cnt     = 0;
        cycle_cnt   = 0;
        stall_mode  = 1;
        gap_max     = 4;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        reset_predictor();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed_alloc();
        test_directed_release();
        test_exhaustion();
        test_random();
        if (err_cnt == 0 && expected_rsp.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (expected_rsp.size() != 0) $error("%0d results missing", expected_rsp.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
